FILE: rtl/isl_pkg.sv
// Shared types and codes for the indexed shift list.
package isl_pkg;

	// Operation codes carried in the func field
	typedef enum logic [2:0] {
		FN_APPEND = 3'd0,
		FN_INSERT = 3'd1,
		FN_REMOVE = 3'd2,
		FN_ERASE  = 3'd3,
		FN_READ   = 3'd4
	} func_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	localparam int unsigned WordW  = 32;
	localparam int unsigned PosW   = 4;
	localparam int unsigned CountW = 5;

	typedef struct packed {
		func_t                     func;
		logic [PosW-1:0]           position;
		logic signed [WordW-1:0]   word_in;
	} op_word_t;

	typedef struct packed {
		status_t                   status;
		logic signed [WordW-1:0]   read_word;
		logic [CountW-1:0]         count;
		logic signed [WordW-1:0]   front_word;
		logic signed [WordW-1:0]   back_word;
	} res_word_t;

	// Per-cycle command broadcast along the row of cells
	typedef struct packed {
		logic ins;
		logic del;
	} cell_ctl_t;

endpackage

FILE: rtl/indexed_shift_list.sv
// Top level of the indexed shift list: decoder, row of cells and result register.
//
// Usage: an ordered list of up to DEPTH signed 32-bit entries. Each word on
// the op channel (op_valid / op_stall / op) is one operation: append, insert
// at position, remove last, erase at position, or read position. Each
// accepted word yields exactly one word on the res channel (res_valid /
// res_stall / res) with status, read word, count, front and back entries.
// Insert and erase move every entry at or above the index at once: each such
// cell takes the new word or its left or right neighbour in the same cycle as
// the operation is accepted. From acceptance, the row is updated first, then
// read, front and back words are selected from it into the result register.
// The result selection must see the row settled, so one operation is in
// flight at a time.
// While a result waits under res_stall, op_stall stays high and the result
// holds. Reset clears the count and both valid flags; entry contents are
// unspecified until written.
module indexed_shift_list #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  op_valid,
	output logic                  op_stall,
	input  isl_pkg::op_word_t     op,
	output logic                  res_valid,
	input  logic                  res_stall,
	output isl_pkg::res_word_t    res
);

	localparam int unsigned IW = $clog2(DEPTH);
	localparam int unsigned FW = $clog2(DEPTH + 1);
	localparam int unsigned RN = (DEPTH < 16) ? DEPTH : 16;

	logic                             accept;
	isl_pkg::cell_ctl_t               ctl;
	logic [IW-1:0]                    target;
	isl_pkg::status_t                 status;
	logic                             read_ok;
	logic [FW-1:0]                    fill;
	logic signed [isl_pkg::WordW-1:0] cell_data [DEPTH];

	logic                             valid_s1;
	isl_pkg::status_t                 status_s1;
	logic                             read_ok_s1;
	logic [isl_pkg::PosW-1:0]         pos_s1;
	logic                             res_valid_q;
	isl_pkg::res_word_t               res_q;
	logic signed [isl_pkg::WordW-1:0] read_sel;
	logic signed [isl_pkg::WordW-1:0] back_sel;

	// Hold off new words while one is in flight or a result is stalled
	assign op_stall = valid_s1 | (res_valid_q & res_stall);
	assign accept   = op_valid & ~op_stall;

	isl_ctrl #(
		.DEPTH (DEPTH),
		.IW    (IW),
		.FW    (FW)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.op      (op),
		.ctl     (ctl),
		.target  (target),
		.status  (status),
		.read_ok (read_ok),
		.fill    (fill)
	);

	// Row of cells; the ends feed back the new word and their own entry
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [isl_pkg::WordW-1:0] left_w;
		logic signed [isl_pkg::WordW-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = op.word_in;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = cell_data[i];
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end
		isl_cell #(
			.IDX (i),
			.IW  (IW)
		) u_cell (
			.clk    (clk),
			.ctl    (ctl),
			.target (target),
			.word   (op.word_in),
			.left   (left_w),
			.right  (right_w),
			.data   (cell_data[i])
		);
	end

	// Record the decoded outcome while the row settles
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1  <= status;
			read_ok_s1 <= read_ok;
			pos_s1     <= op.position;
		end
	end

	// Select the read entry and the tail entry from the settled row
	always_comb begin
		read_sel = '0;
		back_sel = '0;
		for (int i = 0; i < RN; i++) begin
			if (pos_s1 == isl_pkg::PosW'(i)) begin
				read_sel = read_sel | cell_data[i];
			end
		end
		for (int i = 0; i < DEPTH; i++) begin
			if (fill == FW'(i + 1)) begin
				back_sel = back_sel | cell_data[i];
			end
		end
	end

	// Load the result register; drop the valid flag once the word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (valid_s1) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_q.status     <= status_s1;
			res_q.read_word  <= read_ok_s1 ? read_sel : '0;
			res_q.count      <= isl_pkg::CountW'(fill);
			res_q.front_word <= (fill != '0) ? cell_data[0] : '0;
			res_q.back_word  <= back_sel;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Only one operation in flight at a time
	a_single_flight: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> op_stall)
		else $error("operation accepted while another is in flight");

	// Fill never passes the store depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= FW'(DEPTH))
		else $error("fill count beyond depth");

	// A pending result reports the count the row currently holds
	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.count == isl_pkg::CountW'(fill)))
		else $error("result count differs from fill");

	// Every accepted operation reaches the result register after the row update
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 res_valid)
		else $error("accepted operation produced no result");

endmodule

FILE: rtl/isl_cell.sv
// One storage cell of the list: holds one entry and shifts with its neighbours.
module isl_cell #(
	parameter int unsigned IDX = 0,
	parameter int unsigned IW  = 4
) (
	input  logic                              clk,
	input  isl_pkg::cell_ctl_t                ctl,
	input  logic [IW-1:0]                     target,
	input  logic signed [isl_pkg::WordW-1:0]  word,
	input  logic signed [isl_pkg::WordW-1:0]  left,
	input  logic signed [isl_pkg::WordW-1:0]  right,
	output logic signed [isl_pkg::WordW-1:0]  data
);

	logic signed [isl_pkg::WordW-1:0] data_q;
	logic                             at_target;
	logic                             above_target;

	// Place of this cell relative to the operation index
	assign at_target    = (IW'(IDX) == target);
	assign above_target = (IW'(IDX) > target);

	// Take the new word, shift up from the left or shift down from the right
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (at_target) begin
				data_q <= word;
			end else if (above_target) begin
				data_q <= left;
			end
		end else if (ctl.del) begin
			if (at_target || above_target) begin
				data_q <= right;
			end
		end
	end

	assign data = data_q;

endmodule

FILE: rtl/isl_ctrl.sv
// Operation decoder and fill counter for the indexed shift list.
module isl_ctrl #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned IW    = 4,
	parameter int unsigned FW    = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  isl_pkg::op_word_t     op,
	output isl_pkg::cell_ctl_t    ctl,
	output logic [IW-1:0]         target,
	output isl_pkg::status_t      status,
	output logic                  read_ok,
	output logic [FW-1:0]         fill
);

	localparam int unsigned CW = (FW > isl_pkg::PosW) ? FW : isl_pkg::PosW;

	logic [FW-1:0] fill_q;
	logic [FW-1:0] fill_d;
	logic [CW-1:0] pos_c;
	logic [CW-1:0] fill_c;
	logic          full;
	logic          empty;
	logic          ins;
	logic          del;
	logic          pos_is_pos;

	assign full   = (fill_q == FW'(DEPTH));
	assign empty  = (fill_q == '0);
	assign pos_c  = CW'(op.position);
	assign fill_c = CW'(fill_q);

	// Decode the operation against the current fill
	always_comb begin
		status     = isl_pkg::ST_OK;
		ins        = 1'b0;
		del        = 1'b0;
		read_ok    = 1'b0;
		pos_is_pos = 1'b1;
		fill_d     = fill_q;
		unique case (op.func)
			isl_pkg::FN_APPEND: begin
				pos_is_pos = 1'b0;
				if (full) begin
					status = isl_pkg::ST_FULL;
				end else begin
					ins    = 1'b1;
					fill_d = fill_q + FW'(1);
				end
			end
			isl_pkg::FN_INSERT: begin
				if (full) begin
					status = isl_pkg::ST_FULL;
				end else if (pos_c > fill_c) begin
					status = isl_pkg::ST_RANGE;
				end else begin
					ins    = 1'b1;
					fill_d = fill_q + FW'(1);
				end
			end
			isl_pkg::FN_REMOVE: begin
				if (empty) begin
					status = isl_pkg::ST_EMPTY;
				end else begin
					fill_d = fill_q - FW'(1);
				end
			end
			isl_pkg::FN_ERASE: begin
				if (empty) begin
					status = isl_pkg::ST_EMPTY;
				end else if (pos_c >= fill_c) begin
					status = isl_pkg::ST_RANGE;
				end else begin
					del    = 1'b1;
					fill_d = fill_q - FW'(1);
				end
			end
			isl_pkg::FN_READ: begin
				if (empty) begin
					status = isl_pkg::ST_EMPTY;
				end else if (pos_c >= fill_c) begin
					status = isl_pkg::ST_RANGE;
				end else begin
					read_ok = 1'b1;
				end
			end
			default: begin
				status = isl_pkg::ST_OK;
			end
		endcase
	end

	// Append targets the slot just past the tail, the others the given index
	assign target  = pos_is_pos ? IW'(op.position) : IW'(fill_q);
	assign ctl.ins = accept & ins;
	assign ctl.del = accept & del;

	// Update the fill count on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			fill_q <= fill_d;
		end
	end

	assign fill = fill_q;

endmodule

FILE: sim/indexed_shift_list_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the indexed shift list: a directed table, then random phases.
module indexed_shift_list_test;

	localparam int unsigned DEPTH       = 16;
	localparam int          RANDOM_OPS  = 800;
	localparam int          PHASE_LEN   = 50;
	localparam int          QUIET_FROM  = 700;
	localparam int          HOLD_CYCLES = 80;
	localparam int          CYCLE_LIMIT = 400000;

	typedef enum int {
		MIX_GROW,
		MIX_SHRINK,
		MIX_EVEN
	} op_mix_t;

	// One row of the directed table: the op word and, where fixed is set, its result
	typedef struct packed {
		isl_pkg::op_word_t  cmd;
		bit                 fixed;
		isl_pkg::res_word_t want;
	} plan_row_t;

	logic               clk;
	logic               arst_n;
	logic               op_valid;
	logic               op_stall;
	isl_pkg::op_word_t  op;
	logic               res_valid;
	logic               res_stall;
	isl_pkg::res_word_t res;

	// Shadow of the list contents and its fill
	logic signed [isl_pkg::WordW-1:0] list_words [DEPTH];
	int unsigned                      list_fill;

	isl_pkg::res_word_t pending_res [$];
	plan_row_t          plan [$];
	int                 fail_count;
	bit                 idle_on;
	int                 hold_request;
	int                 cycles;

	indexed_shift_list #(
		.DEPTH(DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op_stall (op_stall),
		.op       (op),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	// Apply one operation to the shadow list and return the result word it gives
	function automatic isl_pkg::res_word_t apply_op(input isl_pkg::op_word_t w);
		isl_pkg::res_word_t r;
		int unsigned        p;
		int unsigned        i;
		r        = '0;
		r.status = isl_pkg::ST_OK;
		p        = w.position;
		case (w.func)
			isl_pkg::FN_APPEND: begin
				if (list_fill >= DEPTH) begin
					r.status = isl_pkg::ST_FULL;
				end else begin
					list_words[list_fill] = w.word_in;
					list_fill++;
				end
			end
			isl_pkg::FN_INSERT: begin
				if (list_fill >= DEPTH) begin
					r.status = isl_pkg::ST_FULL;
				end else if (p > list_fill) begin
					r.status = isl_pkg::ST_RANGE;
				end else begin
					for (i = list_fill; i > p; i--)
						list_words[i] = list_words[i-1];
					list_words[p] = w.word_in;
					list_fill++;
				end
			end
			isl_pkg::FN_REMOVE: begin
				if (list_fill == 0) begin
					r.status = isl_pkg::ST_EMPTY;
				end else begin
					list_fill--;
				end
			end
			isl_pkg::FN_ERASE: begin
				if (list_fill == 0) begin
					r.status = isl_pkg::ST_EMPTY;
				end else if (p >= list_fill) begin
					r.status = isl_pkg::ST_RANGE;
				end else begin
					for (i = p; i + 1 < list_fill; i++)
						list_words[i] = list_words[i+1];
					list_fill--;
				end
			end
			isl_pkg::FN_READ: begin
				if (list_fill == 0) begin
					r.status = isl_pkg::ST_EMPTY;
				end else if (p >= list_fill) begin
					r.status = isl_pkg::ST_RANGE;
				end else begin
					r.read_word = list_words[p];
				end
			end
			default: begin
				// unknown codes leave the list alone
			end
		endcase
		r.count = 5'(list_fill);
		if (list_fill != 0) begin
			r.front_word = list_words[0];
			r.back_word  = list_words[list_fill-1];
		end
		return r;
	endfunction

	// Add a row to the directed table
	function automatic void add_row(input isl_pkg::func_t f, input int pos,
			input logic [31:0] w,
			input bit fixed = 1'b0, input isl_pkg::status_t s = isl_pkg::ST_OK,
			input logic [31:0] rd = '0, input int cnt = 0,
			input logic [31:0] fr = '0, input logic [31:0] bk = '0);
		plan_row_t row;
		row                 = '0;
		row.cmd.func        = f;
		row.cmd.position    = 4'(pos);
		row.cmd.word_in     = w;
		row.fixed           = fixed;
		row.want.status     = s;
		row.want.read_word  = rd;
		row.want.count      = 5'(cnt);
		row.want.front_word = fr;
		row.want.back_word  = bk;
		plan = {plan, row};
	endfunction

	// Draw a random op word, weighted by the mix and aimed at valid indexes mostly
	function automatic isl_pkg::op_word_t pick_op(input op_mix_t mix);
		isl_pkg::op_word_t w;
		int unsigned       roll;
		int unsigned       top;
		int unsigned       a, b, c, d;
		logic [2:0]        code;
		w    = '0;
		roll = $urandom_range(0, 99);
		case (mix)
			MIX_GROW: begin
				a = 30; b = 60; c = 70; d = 80;
			end
			MIX_SHRINK: begin
				a = 10; b = 20; c = 50; d = 80;
			end
			default: begin
				a = 20; b = 40; c = 60; d = 80;
			end
		endcase
		if (roll < a) begin
			w.func = isl_pkg::FN_APPEND;
		end else if (roll < b) begin
			w.func = isl_pkg::FN_INSERT;
		end else if (roll < c) begin
			w.func = isl_pkg::FN_REMOVE;
		end else if (roll < d) begin
			w.func = isl_pkg::FN_ERASE;
		end else if (roll < 97) begin
			w.func = isl_pkg::FN_READ;
		end else begin
			code   = 3'($urandom_range(5, 7));
			w.func = isl_pkg::func_t'(code);
		end
		if ($urandom_range(0, 99) < 85 && list_fill != 0) begin
			top = (w.func == isl_pkg::FN_INSERT) ? list_fill : list_fill - 1;
			if (top > 15)
				top = 15;
			w.position = 4'($urandom_range(0, top));
		end else begin
			w.position = 4'($urandom());
		end
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 3))
				0: w.word_in = 32'h7FFF_FFFF;
				1: w.word_in = 32'h8000_0000;
				2: w.word_in = 32'h0000_0000;
				default: w.word_in = 32'hFFFF_FFFF;
			endcase
		end else begin
			w.word_in = $urandom();
		end
		return w;
	endfunction

	// Offer one op word, hold it until taken, then log the result it should give
	task automatic push_op(input isl_pkg::op_word_t w, input bit fixed,
			input isl_pkg::res_word_t want);
		isl_pkg::res_word_t model_res;
		int                 gap;
		gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 15) : 0;
		@(negedge clk);
		if (gap > 0) begin
			op_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		op_valid <= 1'b1;
		op       <= w;
		do @(posedge clk); while (op_stall);
		model_res = apply_op(w);
		pending_res = {pending_res, (fixed ? want : model_res)};
	endtask

	task automatic await_drain();
		while (pending_res.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic signed [31:0] exp_v,
			input logic signed [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("indexed_shift_list_test: errors");
		$finish;
	end

	// Result side: random stall bursts, plus a long hold when asked
	initial begin
		int stall_left;
		res_stall  = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				stall_left   = hold_request;
				hold_request = 0;
			end else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 15);
			end
			if (stall_left > 0) begin
				res_stall <= 1'b1;
				stall_left--;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// Compare each taken result word with the oldest pending one
	initial begin
		isl_pkg::res_word_t want;
		forever begin
			@(posedge clk);
			if (res_valid === 1'b1 && res_stall === 1'b0) begin
				if (pending_res.size() == 0) begin
					$error("result word with nothing pending: status %0d", res.status);
					fail_count++;
				end else begin
					want = pending_res.pop_front();
					check_field("status", want.status, res.status);
					check_field("read_word", want.read_word, res.read_word);
					check_field("count", want.count, res.count);
					check_field("front_word", want.front_word, res.front_word);
					check_field("back_word", want.back_word, res.back_word);
				end
			end
		end
	end

	// Stimulus
	initial begin
		isl_pkg::op_word_t w;
		int                counted;
		int                phase;
		int                k;
		op_mix_t           mix;
		arst_n       = 1'b0;
		op_valid     = 1'b0;
		op           = '0;
		idle_on      = 1'b1;
		hold_request = 0;
		fail_count   = 0;
		list_fill    = 0;
		foreach (list_words[i])
			list_words[i] = '0;

		// Empty list, unknown code, extremes of the word, index zero, range errors
		add_row(isl_pkg::FN_READ, 0, 32'h0, 1'b1, isl_pkg::ST_EMPTY);
		add_row(isl_pkg::FN_REMOVE, 0, 32'h0, 1'b1, isl_pkg::ST_EMPTY);
		add_row(isl_pkg::FN_ERASE, 0, 32'h0, 1'b1, isl_pkg::ST_EMPTY);
		add_row(isl_pkg::func_t'(3'd7), 15, 32'hFFFF_FFFF, 1'b1, isl_pkg::ST_OK);
		add_row(isl_pkg::FN_APPEND, 0, 32'h7FFF_FFFF, 1'b1, isl_pkg::ST_OK, 32'h0, 1,
			32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_row(isl_pkg::FN_APPEND, 15, 32'h8000_0000, 1'b1, isl_pkg::ST_OK, 32'h0, 2,
			32'h7FFF_FFFF, 32'h8000_0000);
		add_row(isl_pkg::FN_READ, 0, 32'h0, 1'b1, isl_pkg::ST_OK, 32'h7FFF_FFFF, 2,
			32'h7FFF_FFFF, 32'h8000_0000);
		add_row(isl_pkg::FN_INSERT, 3, 32'h1234_5678, 1'b1, isl_pkg::ST_RANGE, 32'h0, 2,
			32'h7FFF_FFFF, 32'h8000_0000);
		add_row(isl_pkg::FN_ERASE, 15, 32'h0, 1'b1, isl_pkg::ST_RANGE, 32'h0, 2,
			32'h7FFF_FFFF, 32'h8000_0000);
		// insert at the count behaves as an append
		add_row(isl_pkg::FN_INSERT, 2, 32'hFFFF_FFFF);
		add_row(isl_pkg::FN_INSERT, 0, 32'h0000_0000);
		add_row(isl_pkg::FN_INSERT, 1, 32'h5A5A_5A5A);
		// grow to a full list with a mix of appends and inserts
		for (k = 0; k < 11; k++) begin
			if (k % 3 == 0)
				add_row(isl_pkg::FN_APPEND, 0, 32'h0101_0101 * (k + 1));
			else
				add_row(isl_pkg::FN_INSERT, (k * 7) % (6 + k), ~(32'h0202_0202 * k));
		end
		add_row(isl_pkg::FN_APPEND, 0, 32'hDEAD_BEEF);
		add_row(isl_pkg::FN_INSERT, 0, 32'hCAFE_F00D);
		add_row(isl_pkg::FN_READ, 15, 32'h0);
		add_row(isl_pkg::FN_ERASE, 0, 32'h0);
		add_row(isl_pkg::FN_INSERT, 15, 32'h8000_0000);
		add_row(isl_pkg::func_t'(3'd6), 3, 32'h0);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Walk the directed table
		foreach (plan[i])
			push_op(plan[i].cmd, plan[i].fixed, plan[i].want);

		// Random phases: growing, shrinking and even mixes, with a long result hold
		// twice, a full drain once, and no idling near the end
		counted = 0;
		phase   = 0;
		while (counted < RANDOM_OPS) begin
			mix     = op_mix_t'(phase % 3);
			idle_on = (phase % 4 != 2) && (phase != 3) && (counted < QUIET_FROM);
			if (phase == 3 || phase == 9)
				hold_request = HOLD_CYCLES;
			if (phase == 6) begin
				// drop valid so the last word is not taken twice while draining
				@(negedge clk);
				op_valid <= 1'b0;
				await_drain();
			end
			repeat (PHASE_LEN) begin
				w = pick_op(mix);
				push_op(w, 1'b0, '0);
				if (w.func <= isl_pkg::FN_READ)
					counted++;
			end
			phase++;
		end

		// Drop valid, let the last results out, then report
		@(negedge clk);
		op_valid <= 1'b0;
		await_drain();
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("indexed_shift_list_test: clean");
		end else begin
			$display("indexed_shift_list_test: errors");
		end
		$finish;
	end

endmodule
